>>> hdl/pbk_pkg.sv
// Shared types, constants and block builders for the PBKDF2-HMAC-SHA1 key deriver.
// No dependencies; every other file in hdl/ but pbk_ram imports this package.
package pbk_pkg;

	localparam int ITERATIONS     = 4096;
	localparam int MAX_PW_BYTES   = 64;
	localparam int MAX_SALT_BYTES = 32;
	localparam int KEY_BYTES      = 64;
	localparam int PW_AW          = $clog2(MAX_PW_BYTES);
	localparam int CNT_W          = $clog2(MAX_PW_BYTES + 1);
	localparam int KEY_CNT_W      = $clog2(KEY_BYTES + 1);
	localparam int ITER_W         = $clog2(ITERATIONS + 1);
	localparam int SLEN_W         = 6;
	localparam int PADDR_W        = 6;

	localparam logic [2:0] REG_SALT0 = 3'd0;
	localparam logic [2:0] REG_SALT1 = 3'd1;
	localparam logic [2:0] REG_SALT2 = 3'd2;
	localparam logic [2:0] REG_SALT3 = 3'd3;
	localparam logic [2:0] REG_SLEN  = 3'd4;

	localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0};
	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5C;

	typedef struct packed {
		logic [7:0] password_byte;
		logic       final_byte;
	} pw_item_t;

	typedef struct packed {
		logic [63:0] key_word;
		logic [1:0]  word_index;
		logic        last_word;
		logic        too_long;
	} key_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic             too_long;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_PAD, ST_SIN, ST_SOUT, ST_IIN, ST_IOUT, ST_EMIT
	} bk_state_t;

	// Final HMAC block over salt || INT(blkno), after the 64-byte pad block.
	function automatic logic [511:0] salt_block(input logic [255:0] salt,
		input logic [SLEN_W-1:0] slen, input logic [7:0] blkno);
		logic [511:0] b;
		logic [11:0]  bits;
		int j;
		b = '0;
		for (j = 0; j < MAX_SALT_BYTES; j++) begin
			if (SLEN_W'(j) < slen) b[511-8*j -: 8] = salt[255-8*j -: 8];
		end
		for (j = 0; j < 56; j++) begin
			if (7'(j) == {1'b0, slen} + 7'd3) b[511-8*j -: 8] = blkno;
			else if (7'(j) == {1'b0, slen} + 7'd4) b[511-8*j -: 8] = 8'h80;
		end
		bits = ({6'd0, slen} + 12'd68) << 3;
		b[63:0] = 64'(bits);
		return b;
	endfunction

	// Final HMAC block over a 20-byte digest.
	function automatic logic [511:0] digest_block(input logic [159:0] d);
		return {d, 8'h80, 280'd0, 64'd672};
	endfunction

endpackage

>>> hdl/pbk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/pbk_front.sv
// Front end: takes password bytes into the password RAM and queues one derivation job.
// Depends on pbk_pkg.
module pbk_front import pbk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pw_valid,
	input  pw_item_t         pw_item,
	output logic             pw_stall,
	output logic             ram_we,
	output logic [PW_AW-1:0] ram_waddr,
	output logic [7:0]       ram_wdata,
	output logic             job_valid,
	output job_t             job,
	input  logic             job_pop
);

	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic             ovf_q, ovf_nx;
	logic             jv_q;
	job_t             job_q;
	logic             acc, room;

	// Hold all bytes while a job waits: the back end still has to copy the RAM.
	assign pw_stall  = jv_q;
	assign acc       = pw_valid && !jv_q;
	assign room      = cnt_q < CNT_W'(MAX_PW_BYTES);
	assign cnt_nx    = room ? cnt_q + 1'b1 : cnt_q;
	assign ovf_nx    = ovf_q || !room;
	assign ram_we    = acc && room;
	assign ram_waddr = PW_AW'(cnt_q);
	assign ram_wdata = pw_item.password_byte;
	assign job_valid = jv_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			jv_q  <= 1'b0;
		end else begin
			if (job_pop) jv_q <= 1'b0;
			if (acc) begin
				if (pw_item.final_byte) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
					jv_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_nx;
					ovf_q <= ovf_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && pw_item.final_byte) begin
			job_q.n        <= cnt_nx;
			job_q.too_long <= ovf_nx;
		end
	end

endmodule

>>> hdl/pbk_sha1.sv
// SHA-1 compression unit, one round per cycle, 16-word rolling message schedule.
// Depends on pbk_pkg.
module pbk_sha1 import pbk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] blk,
	input  logic [159:0] hin,
	output logic         busy,
	output logic         done,
	output logic [159:0] hout
);

	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  w_q [16];
	logic [6:0]   rnd_q;
	logic         run_q, fin_q, done_q;
	logic [159:0] h_q, hout_q;
	logic [31:0]  f, k, t, wn, wx;
	int i;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wn = {wx[30:0], wx[31]};
	end

	assign busy = run_q || fin_q;
	assign done = done_q;
	assign hout = hout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == 7'd79) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= hin;
			a_q <= hin[159:128];
			b_q <= hin[127:96];
			c_q <= hin[95:64];
			d_q <= hin[63:32];
			e_q <= hin[31:0];
			for (i = 0; i < 16; i++) w_q[i] <= blk[511-32*i -: 32];
		end else if (run_q) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
		if (fin_q) begin
			hout_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
				h_q[63:32] + d_q, h_q[31:0] + e_q};
		end
	end

endmodule

>>> hdl/pbk_back.sv
// Back end: copies the key, runs both PBKDF2 block chains on two SHA-1 units in step,
// then emits the four key words. Depends on pbk_pkg and pbk_sha1.
module pbk_back import pbk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  job_t              job,
	output logic              job_pop,
	output logic [PW_AW-1:0]  ram_raddr,
	input  logic [7:0]        ram_rdata,
	input  logic [255:0]      salt,
	input  logic [SLEN_W-1:0] salt_len,
	output logic              key_valid,
	input  logic              key_stall,
	output key_item_t         key_item
);

	bk_state_t st_q, st_d;
	logic [KEY_CNT_W-1:0] rd_cnt_q;
	logic                 cap_s1;
	logic [5:0]           idx_s1;
	logic [CNT_W-1:0]     n_q;
	logic                 tl_q;
	logic [511:0]         key_q;
	logic [159:0]         inner_q, outer_q, tmp0_q, tmp1_q, dig0_q, dig1_q, acc0_q, acc1_q;
	logic [ITER_W-1:0]    iter_q;
	logic [1:0]           wc_q;
	logic                 kv_q, go_q, start, ld, last_iter;
	key_item_t            ki_q;
	logic [511:0]         blk0, blk1;
	logic [159:0]         h0, h1, out0, out1;
	logic                 busy0, busy1, done0, done1;
	logic [SLEN_W-1:0]    slen;
	logic [255:0]         key256, kshift;

	assign slen      = (salt_len > SLEN_W'(MAX_SALT_BYTES)) ? SLEN_W'(MAX_SALT_BYTES)
		: salt_len;
	assign ld        = !kv_q || !key_stall;
	assign last_iter = (iter_q + 1'b1) == ITER_W'(ITERATIONS);
	assign ram_raddr = PW_AW'(rd_cnt_q);
	assign key_valid = kv_q;
	assign key_item  = ki_q;
	assign key256    = {acc0_q, acc1_q[159:64]};
	assign kshift    = key256 << {wc_q, 6'd0};

	always_comb begin
		st_d    = st_q;
		job_pop = 1'b0;
		start   = 1'b0;
		unique case (st_q)
			ST_IDLE: if (job_valid) st_d = ST_LOAD;
			ST_LOAD: begin
				if (cap_s1 && idx_s1 == 6'd63) begin
					st_d    = ST_PAD;
					job_pop = 1'b1;
				end
			end
			ST_PAD: begin
				start = go_q;
				if (done0) st_d = ST_SIN;
			end
			ST_SIN: begin
				start = go_q;
				if (done0) st_d = ST_SOUT;
			end
			ST_SOUT: begin
				start = go_q;
				if (done0) st_d = (ITERATIONS == 1) ? ST_EMIT : ST_IIN;
			end
			ST_IIN: begin
				start = go_q;
				if (done0) st_d = ST_IOUT;
			end
			ST_IOUT: begin
				start = go_q;
				if (done0) st_d = last_iter ? ST_EMIT : ST_IIN;
			end
			ST_EMIT: if (ld && wc_q == 2'd3) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (st_q)
			ST_PAD: begin
				blk0 = key_q ^ {KEY_BYTES{IPAD}};
				blk1 = key_q ^ {KEY_BYTES{OPAD}};
				h0   = SHA1_IV;
				h1   = SHA1_IV;
			end
			ST_SIN: begin
				blk0 = salt_block(salt, slen, 8'd1);
				blk1 = salt_block(salt, slen, 8'd2);
				h0   = inner_q;
				h1   = inner_q;
			end
			ST_IIN: begin
				blk0 = digest_block(dig0_q);
				blk1 = digest_block(dig1_q);
				h0   = inner_q;
				h1   = inner_q;
			end
			default: begin
				blk0 = digest_block(tmp0_q);
				blk1 = digest_block(tmp1_q);
				h0   = outer_q;
				h1   = outer_q;
			end
		endcase
	end

	pbk_sha1 u_sha0 (.clk(clk), .arst_n(arst_n), .start(start), .blk(blk0), .hin(h0),
		.busy(busy0), .done(done0), .hout(out0));
	pbk_sha1 u_sha1 (.clk(clk), .arst_n(arst_n), .start(start), .blk(blk1), .hin(h1),
		.busy(busy1), .done(done1), .hout(out1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			rd_cnt_q <= '0;
			cap_s1   <= 1'b0;
			iter_q   <= '0;
			wc_q     <= '0;
			kv_q     <= 1'b0;
			go_q     <= 1'b0;
		end else begin
			st_q   <= st_d;
			// Launch both units once on entry to each hashing step.
			go_q   <= (st_d != st_q) && (st_d == ST_PAD || st_d == ST_SIN ||
				st_d == ST_SOUT || st_d == ST_IIN || st_d == ST_IOUT);
			cap_s1 <= (st_q == ST_LOAD) && rd_cnt_q < KEY_CNT_W'(KEY_BYTES);
			if (st_q == ST_IDLE) begin
				rd_cnt_q <= '0;
				wc_q     <= '0;
			end else if (st_q == ST_LOAD && rd_cnt_q < KEY_CNT_W'(KEY_BYTES)) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (st_q == ST_SOUT && done0) iter_q <= ITER_W'(1);
			else if (st_q == ST_IOUT && done0) iter_q <= iter_q + 1'b1;
			if (ld) kv_q <= (st_q == ST_EMIT);
			if (st_q == ST_EMIT && ld) wc_q <= wc_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[5:0];
		if (st_q == ST_IDLE && job_valid) begin
			n_q  <= job.n;
			tl_q <= job.too_long;
		end
		// Shift the key in, earliest byte ending up in the top bits; zero past the end.
		if (cap_s1) key_q <= {key_q[503:0], ({1'b0, idx_s1} < n_q) ? ram_rdata : 8'h00};
		if (done0) begin
			unique case (st_q) inside
				ST_PAD: begin
					inner_q <= out0;
					outer_q <= out1;
				end
				ST_SIN, ST_IIN: begin
					tmp0_q <= out0;
					tmp1_q <= out1;
				end
				ST_SOUT: begin
					dig0_q <= out0;
					dig1_q <= out1;
					acc0_q <= out0;
					acc1_q <= out1;
				end
				ST_IOUT: begin
					dig0_q <= out0;
					dig1_q <= out1;
					acc0_q <= acc0_q ^ out0;
					acc1_q <= acc1_q ^ out1;
				end
				default: ;
			endcase
		end
		if (st_q == ST_EMIT && ld) begin
			ki_q.key_word   <= kshift[255:192];
			ki_q.word_index <= wc_q;
			ki_q.last_word  <= (wc_q == 2'd3);
			ki_q.too_long   <= tl_q;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy0 && !busy1) else $error("hash unit started while busy");
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done0 == done1) else $error("block chains out of step");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("pop of empty job queue");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(kv_q && ki_q.last_word) |-> ki_q.word_index == 2'd3)
		else $error("last word flag on wrong index");

endmodule

>>> hdl/pbkdf2_hmac_sha1_key_derive.sv
// From the final password byte the back end copies the key, hashes the pad, salt and
// iteration blocks, then emits the four key words; one password is derived at a time.
// Throughput is set by the two SHA-1 units at one round per cycle, one per block chain.
// The next password's bytes are taken once the key copy of the current one is done.
// Reset (arst_n low, asynchronous) clears control state and the salt registers.
module pbkdf2_hmac_sha1_key_derive import pbk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               pw_valid,
	input  pw_item_t           pw_item,
	output logic               pw_stall,
	output logic               key_valid,
	input  logic               key_stall,
	output key_item_t          key_item
);

	logic [63:0]        salt0_q, salt1_q, salt2_q, salt3_q;
	logic [SLEN_W-1:0]  slen_q;
	logic [2:0]         ridx;
	logic               wr;
	logic               ram_we;
	logic [PW_AW-1:0]   ram_waddr, ram_raddr;
	logic [7:0]         ram_wdata, ram_rdata;
	logic               job_valid, job_pop;
	job_t               job;

	assign pready = 1'b1;
	assign ridx   = paddr[5:3];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt0_q <= '0;
			salt1_q <= '0;
			salt2_q <= '0;
			salt3_q <= '0;
			slen_q  <= '0;
		end else if (wr) begin
			unique case (ridx)
				REG_SALT0: salt0_q <= pwdata;
				REG_SALT1: salt1_q <= pwdata;
				REG_SALT2: salt2_q <= pwdata;
				REG_SALT3: salt3_q <= pwdata;
				REG_SLEN:  slen_q  <= pwdata[SLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_SALT0: prdata = salt0_q;
			REG_SALT1: prdata = salt1_q;
			REG_SALT2: prdata = salt2_q;
			REG_SALT3: prdata = salt3_q;
			REG_SLEN:  prdata = 64'(slen_q);
			default:   prdata = '0;
		endcase
	end

	pbk_front u_front (
		.clk(clk), .arst_n(arst_n), .pw_valid(pw_valid), .pw_item(pw_item),
		.pw_stall(pw_stall), .ram_we(ram_we), .ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata), .job_valid(job_valid), .job(job), .job_pop(job_pop)
	);

	pbk_ram #(.WIDTH(8), .DEPTH(MAX_PW_BYTES)) u_pw_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	pbk_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job), .job_pop(job_pop),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
		.salt({salt0_q, salt1_q, salt2_q, salt3_q}), .salt_len(slen_q),
		.key_valid(key_valid), .key_stall(key_stall), .key_item(key_item)
	);

endmodule

>>> test/tb_top.sv
// Testbench for pbkdf2_hmac_sha1_key_derive: drives password bytes and salt registers,
// predicts every key word with its own SHA-1 / HMAC / PBKDF2 model, and checks the beats.
// Depends on pbk_pkg (payload structs, register indexes, PADDR_W).
`timescale 1ns / 100ps

module tb_top;
	import pbk_pkg::*;

	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int      HOLD_CYCLES = 400;
	localparam int      DRAIN_CYCLES = 100;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [63:0]        pwdata;
	logic [63:0]        prdata;
	logic               pready;
	logic               pw_valid;
	pw_item_t           pw_item;
	logic               pw_stall;
	logic               key_valid;
	logic               key_stall;
	key_item_t          key_item;

	pbkdf2_hmac_sha1_key_derive uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pw_valid(pw_valid), .pw_item(pw_item), .pw_stall(pw_stall),
		.key_valid(key_valid), .key_stall(key_stall), .key_item(key_item)
	);

	// model state
	logic [63:0] salt_q [4];
	logic [5:0]  salt_len_q;
	logic [7:0]  pw_buf [$];
	logic        pw_dropped;
	key_item_t   key_expect [$];

	int     errors;
	int     keys_checked;
	int     passwords_sent;
	int     bytes_sent;
	longint cycles = 0;
	bit     hold_next;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d key words pending", cycles,
				key_expect.size());
			$display("FAIL pbkdf2_hmac_sha1_key_derive");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
		errors++;
		$display("mismatch %s: expected %h got %h (cycle %0d)", what, exp_v, got_v, cycles);
	endtask

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [159:0] sha1_fold(input logic [159:0] h, input logic [511:0] blk);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		int i;
		for (i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
		for (i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		{a, b, c, d, e} = h;
		for (i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rol(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
	endfunction

	// second block of an HMAC pass: msg bytes after the 64-byte pad block
	function automatic logic [511:0] tail_block(input logic [7:0] msg [40], input int len);
		logic [511:0] blk;
		logic [63:0]  bits;
		int i;
		blk = '0;
		for (i = 0; i < len; i++) blk[511-8*i -: 8] = msg[i];
		blk[511-8*len -: 8] = 8'h80;
		bits = 64'(64 + len) * 8;
		blk[63:0] = bits;
		return blk;
	endfunction

	function automatic logic [159:0] hmac_tail(input logic [159:0] imid, input logic [159:0] omid,
		input logic [511:0] blk);
		logic [159:0] inner;
		inner = sha1_fold(imid, blk);
		return sha1_fold(omid, {inner, 8'h80, 280'd0, 64'd672});
	endfunction

	// PBKDF2 blocks 1 and 2 over the buffered password; returns both accumulators
	function automatic logic [319:0] pmk_blocks();
		logic [511:0] ipad_blk, opad_blk;
		logic [159:0] imid, omid;
		logic [159:0] dig [2];
		logic [159:0] acc [2];
		logic [7:0]   msg [40];
		logic [7:0]   kb;
		int slen, i, blk, it;
		slen = (salt_len_q > 6'd32) ? 32 : int'(salt_len_q);
		for (i = 0; i < 64; i++) begin
			kb = (i < pw_buf.size()) ? pw_buf[i] : 8'h00;
			ipad_blk[511-8*i -: 8] = kb ^ IPAD;
			opad_blk[511-8*i -: 8] = kb ^ OPAD;
		end
		imid = sha1_fold(SHA1_IV, ipad_blk);
		omid = sha1_fold(SHA1_IV, opad_blk);
		for (i = 0; i < 40; i++) msg[i] = 8'h00;
		for (i = 0; i < slen; i++) msg[i] = salt_q[i/8][63-8*(i%8) -: 8];
		for (blk = 0; blk < 2; blk++) begin
			msg[slen+3] = 8'(blk + 1);
			dig[blk] = hmac_tail(imid, omid, tail_block(msg, slen + 4));
			acc[blk] = dig[blk];
		end
		for (it = 1; it < ITERATIONS; it++) begin
			for (blk = 0; blk < 2; blk++) begin
				dig[blk] = hmac_tail(imid, omid, {dig[blk], 8'h80, 280'd0, 64'd672});
				acc[blk] ^= dig[blk];
			end
		end
		return {acc[0], acc[1]};
	endfunction

	task automatic accept_byte(input pw_item_t it);
		logic [319:0] acc;
		key_item_t    kw;
		int k;
		if (pw_buf.size() < MAX_PW_BYTES) pw_buf.push_back(it.password_byte);
		else pw_dropped = 1'b1;
		if (it.final_byte) begin
			acc = pmk_blocks();
			for (k = 0; k < 4; k++) begin
				kw.key_word   = acc[319-64*k -: 64];
				kw.word_index = 2'(k);
				kw.last_word  = (k == 3);
				kw.too_long   = pw_dropped;
				key_expect.push_back(kw);
			end
			pw_buf.delete();
			pw_dropped = 1'b0;
			passwords_sent++;
		end
	endtask

	// one beat on the password channel; valid stays high when no gap is drawn
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int  gap;
		logic s;
		pw_item_t it;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			pw_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.password_byte = b;
		it.final_byte    = fin;
		pw_valid <= 1'b1;
		pw_item  <= it;
		do begin
			@(negedge clk);
			s = pw_stall;
			@(posedge clk);
		end while (s);
		bytes_sent++;
		accept_byte(it);
	endtask

	task automatic send_password(input int len, input bit fixed, input logic [7:0] fill);
		int i;
		for (i = 0; i < len; i++)
			send_byte(fixed ? fill : 8'($urandom), i == len - 1);
	endtask

	task automatic quiesce();
		pw_valid <= 1'b0;
		@(posedge clk);
		while (key_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 3'b000});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= REG_SALT3) salt_q[idx[1:0]] = v;
		else if (idx == REG_SLEN) salt_len_q = v[5:0];
	endtask

	task automatic set_salt(input logic [63:0] w0, input logic [63:0] w1,
		input logic [63:0] w2, input logic [63:0] w3, input logic [5:0] len);
		reg_write(REG_SALT0, w0);
		reg_write(REG_SALT1, w1);
		reg_write(REG_SALT2, w2);
		reg_write(REG_SALT3, w3);
		reg_write(REG_SLEN, {58'd0, len});
	endtask

	// receiver: per beat a random hold, or one long hold when asked
	initial begin : key_sink
		int  gap;
		logic s;
		key_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			gap = hold_next ? HOLD_CYCLES
				: (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
			hold_next = 1'b0;
			if (gap > 0) begin
				key_stall <= 1'b1;
				do @(negedge clk); while (!key_valid);
				repeat (gap) @(posedge clk);
			end
			key_stall <= 1'b0;
			do begin
				@(negedge clk);
				s = key_valid;
				@(posedge clk);
			end while (!s);
		end
	end

	always @(negedge clk) begin
		if (arst_n && key_valid && !key_stall) begin
			if (key_expect.size() == 0) begin
				report("unexpected key word", 64'd0, key_item.key_word);
			end else begin
				if (key_item.key_word !== key_expect[0].key_word)
					report("key_word", key_expect[0].key_word, key_item.key_word);
				if (key_item.word_index !== key_expect[0].word_index)
					report("word_index", 64'(key_expect[0].word_index), 64'(key_item.word_index));
				if (key_item.last_word !== key_expect[0].last_word)
					report("last_word", 64'(key_expect[0].last_word), 64'(key_item.last_word));
				if (key_item.too_long !== key_expect[0].too_long)
					report("too_long", 64'(key_expect[0].too_long), 64'(key_item.too_long));
				void'(key_expect.pop_front());
				keys_checked++;
			end
		end
	end

	task automatic test_short_passwords();
		// empty salt, then a full all-ones salt; plus a write past the register list
		send_password(1, 1'b1, 8'h00);
		quiesce();
		set_salt('1, '1, '1, '1, 6'd32);
		reg_write(3'd5, '1);
		send_password(1, 1'b1, 8'hFF);
		quiesce();
	endtask

	task automatic test_full_password();
		// salt length above the maximum saturates; 64 bytes are used as the key directly
		set_salt(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, '0, 64'h8000000000000001, 6'd63);
		send_password(64, 1'b0, 8'h00);
		quiesce();
	endtask

	task automatic test_overlong_with_backpressure();
		// drop two bytes, push the next password while the first is still derived, and ask for a long key hold
		set_salt(64'h6C696E6B73797300, '0, '0, '0, 6'd7);
		hold_next = 1'b1;
		send_password(66, 1'b0, 8'h00);
		send_password($urandom_range(2, 8), 1'b0, 8'h00);
		quiesce();
	endtask

	task automatic test_random_passwords(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			set_salt({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, 6'($urandom_range(0, 40)));
			send_password($urandom_range(1, 14), 1'b0, 8'h00);
			quiesce();
		end
	endtask

	initial begin
		errors         = 0;
		keys_checked   = 0;
		passwords_sent = 0;
		bytes_sent     = 0;
		hold_next      = 1'b0;
		pw_dropped     = 1'b0;
		salt_q         = '{default: '0};
		salt_len_q     = '0;
		arst_n   = 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		pw_valid <= 1'b0;
		pw_item  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_passwords();
		test_full_password();
		test_overlong_with_backpressure();
		test_random_passwords(2);

		$display("covered %0d passwords (%0d bytes) and %0d key words, including empty and",
			passwords_sent, bytes_sent, keys_checked);
		$display("saturated salts, 64-byte and overlong keys, and a long output hold");
		if (errors == 0) begin
			$display("PASS pbkdf2_hmac_sha1_key_derive");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL pbkdf2_hmac_sha1_key_derive");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/pbk_pkg.sv
hdl/pbk_ram.sv
hdl/pbk_front.sv
hdl/pbk_sha1.sv
hdl/pbk_back.sv
hdl/pbkdf2_hmac_sha1_key_derive.sv
test/tb_top.sv
